FILE: hw/rtl/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
package uer_pkg;

    localparam int TIME_W     = 16;
    localparam int SPEED_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int SER_W     = 16;
    localparam int SER_CNT_W = $clog2(SER_W);
    localparam int MCAND_W   = 20;
    localparam int PROD_W    = 36;
    localparam int QUO_W     = 16;
    localparam int DIST_W    = 11;
    localparam int CM_W      = 12;
    localparam int MILLI_W   = 10;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ECHO = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED    = 1'd1;

    localparam logic [TIME_W-1:0]  PERIOD_RESET  = 16'd3000;
    localparam logic [TIME_W-1:0]  PERIOD_MIN    = 16'd3;
    localparam logic [SPEED_W-1:0] SPEED_RESET   = 6'd33;
    localparam logic [MCAND_W-1:0] US_PER_SECOND = 20'd1000000;
    localparam logic [QUO_W-1:0]   PULSE_MAX     = 16'hFFFF;
    localparam int                 DIST_DIVISOR  = 2000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_US,
        ST_DIV_US,
        ST_MUL_DIST,
        ST_DIV_DIST,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/uer_smul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
module uer_smul
    import uer_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SER_W-1:0]   a,
    input  logic [MCAND_W-1:0] b,
    output logic               done,
    output logic [PROD_W-1:0]  prod
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SER_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SER_W-1:0]     a_reg, a_next;
    logic [MCAND_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SER_CNT_W'(SER_W - 1);
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                     + (a_reg[SER_W-1] ? PROD_W'(b_reg) : '0);
            a_next   = {a_reg[SER_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: hw/rtl/uer_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle, with quotient overflow flag
module uer_sdiv
    import uer_pkg::*;
#(
    parameter int DEN_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf,
    output logic [DEN_W-1:0]  rem
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PROD_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            num_next = {num_reg[PROD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign rem  = rem_reg;

endmodule

FILE: hw/rtl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger: trigger timebase, echo pairing and range sequencer
//
// Every item gives exactly one result item. A timebase tick, and an echo edge that does not
// close a pulse, have their result loaded into the output register on the
// accepting edge, and the next item can be taken at the following edge only if that result
// leaves at the same edge; a waiting result holds off the input. A falling edge that closes
// a pulse starts the range sequence: the bit-serial multiplier forms ticks * 1000000, the
// bit-serial restoring divider divides it by CAPTURE_TICKS_PER_SECOND (one quotient bit per
// bit of the 36-bit numerator), the multiplier forms sound_speed * pulse_us, the divider
// divides that by 2000, and the result is loaded into the output register once that register
// is free; no new item is taken until that result is in the output register, so the next
// item can be taken in the cycle after at the earliest.
// Pulse width is ticks * 1000000 / CAPTURE_TICKS_PER_SECOND, saturated at 65535 us; the
// distance is sound_speed * pulse_us / 2000 as whole cm and thousandths.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int CAPTURE_TICKS_PER_SECOND = 62500
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // capture_time, edge_rising
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // trigger_level, pulse_us, distance_cm, distance_milli
    output logic                  m_tuser,   // measurement_valid
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CTPS_W = $clog2(CAPTURE_TICKS_PER_SECOND + 1);
    localparam int DEN_W  = (CTPS_W > DIST_W) ? CTPS_W : DIST_W;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  trigger_period_reg;
    logic [SPEED_W-1:0] sound_speed_reg;
    logic [TIME_W-1:0]  tick_counter_reg, tick_counter_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic               await_falling_reg, await_falling_next;
    logic               trigger_reg, trigger_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_trigger_reg;
    logic               out_meas_reg;
    logic [QUO_W-1:0]   out_pulse_reg;
    logic [CM_W-1:0]    out_cm_reg;
    logic [MILLI_W-1:0] out_milli_reg;

    logic [QUO_W-1:0]   pulse_reg;
    logic [CM_W-1:0]    cm_reg;
    logic [MILLI_W-1:0] milli_reg;

    logic [TIME_W-1:0]  capture_time;
    logic               edge_rising;
    logic               command;
    logic               accept;
    logic               slot_free;
    logic               closes_pulse;
    logic [TIME_W-1:0]  period_eff;
    logic [TIME_W-1:0]  tick_inc;
    logic [TIME_W-1:0]  ticks;

    logic               load_now;
    logic               load_done;
    logic               mul_start;
    logic               div_start;
    logic [SER_W-1:0]   mul_a;
    logic [MCAND_W-1:0] mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic               div_ovf;
    logic [DEN_W-1:0]   div_rem;
    logic [QUO_W-1:0]   pulse_sat;

    assign capture_time = s_tdata[TIME_W-1:0];
    assign edge_rising  = s_tdata[TIME_W];
    assign command      = s_tuser;

    assign slot_free    = !out_valid_reg || m_tready;
    assign accept       = s_tvalid && s_tready;
    assign closes_pulse = (command == CMD_ECHO) && !edge_rising && await_falling_reg;
    assign ticks        = capture_time - start_time_reg;
    assign pulse_sat    = div_ovf ? PULSE_MAX : div_quo;

    // trigger timebase
    assign period_eff = (trigger_period_reg < PERIOD_MIN) ? PERIOD_MIN : trigger_period_reg;
    assign tick_inc   = tick_counter_reg + 1'b1;

    always_comb
    begin
        tick_counter_next  = tick_counter_reg;
        trigger_next       = trigger_reg;
        start_time_next    = start_time_reg;
        await_falling_next = await_falling_reg;
        if (accept)
        begin
            if (command == CMD_TICK)
            begin
                if (tick_inc == 16'd1)
                    trigger_next = 1'b1;
                if (tick_inc == 16'd2)
                    trigger_next = 1'b0;
                tick_counter_next = (tick_inc >= period_eff) ? '0 : tick_inc;
            end
            else if (edge_rising)
            begin
                if (!await_falling_reg)
                begin
                    start_time_next    = capture_time;
                    await_falling_next = 1'b1;
                end
            end
            else
            begin
                await_falling_next = 1'b0;
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && closes_pulse)
                    state_next = ST_MUL_US;
            end
            ST_MUL_US:
            begin
                if (mul_done)
                    state_next = ST_DIV_US;
            end
            ST_DIV_US:
            begin
                if (div_done)
                    state_next = ST_MUL_DIST;
            end
            ST_MUL_DIST:
            begin
                if (mul_done)
                    state_next = ST_DIV_DIST;
            end
            ST_DIV_DIST:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        load_now  = 1'b0;
        load_done = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = ticks;
        mul_b     = US_PER_SECOND;
        div_den   = DEN_W'(CAPTURE_TICKS_PER_SECOND);
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = slot_free;
                load_now  = accept && !closes_pulse;
                mul_start = accept && closes_pulse;
            end
            ST_MUL_US:
            begin
                div_start = mul_done;
            end
            ST_DIV_US:
            begin
                mul_start = div_done;
                mul_a     = pulse_sat;
                mul_b     = MCAND_W'(sound_speed_reg);
            end
            ST_MUL_DIST:
            begin
                div_start = mul_done;
                div_den   = DEN_W'(DIST_DIVISOR);
            end
            ST_DIV_DIST:
            begin
                div_den = DEN_W'(DIST_DIVISOR);
            end
            ST_DONE:
            begin
                load_done = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    uer_smul u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    uer_sdiv #(
        .DEN_W (DEN_W)
    ) u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf),
        .rem   (div_rem)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_now || load_done)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            trigger_period_reg <= PERIOD_RESET;
            sound_speed_reg    <= SPEED_RESET;
            tick_counter_reg   <= '0;
            start_time_reg     <= '0;
            await_falling_reg  <= 1'b0;
            trigger_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tick_counter_reg  <= tick_counter_next;
            start_time_reg    <= start_time_next;
            await_falling_reg <= await_falling_next;
            trigger_reg       <= trigger_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRIGGER_PERIOD: trigger_period_reg <= cfg_data[TIME_W-1:0];
                    CFG_SOUND_SPEED:    sound_speed_reg    <= cfg_data[SPEED_W-1:0];
                    default:            trigger_period_reg <= trigger_period_reg;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_US && div_done)
            pulse_reg <= pulse_sat;
        if (state_reg == ST_DIV_DIST && div_done)
        begin
            cm_reg    <= div_quo[CM_W-1:0];
            milli_reg <= div_rem[MILLI_W:1];
        end
        if (load_now)
        begin
            out_trigger_reg <= trigger_next;
            out_meas_reg    <= 1'b0;
            out_pulse_reg   <= '0;
            out_cm_reg      <= '0;
            out_milli_reg   <= '0;
        end
        else if (load_done)
        begin
            out_trigger_reg <= trigger_reg;
            out_meas_reg    <= 1'b1;
            out_pulse_reg   <= pulse_reg;
            out_cm_reg      <= cm_reg;
            out_milli_reg   <= milli_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_meas_reg;
    assign m_tdata  = {1'b0, out_milli_reg, out_cm_reg, out_pulse_reg, out_trigger_reg};

endmodule

FILE: bench/ultrasonic_echo_ranger_tb.sv
// self-checking testbench of the ultrasonic echo ranger: directed table, random pulses, idle/stall
module ultrasonic_echo_ranger_tb
    import uer_pkg::*;
();

    localparam longint TICKS_PER_SEC = 62500;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STALL_LIMIT   = 3000;
    localparam int     DRAIN_CYCLES  = 150;

    typedef struct packed {
        logic               trig;
        logic               valid;
        logic [TIME_W-1:0]  pulse;
        logic [CM_W-1:0]    cm;
        logic [MILLI_W-1:0] milli;
    } range_result_t;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] cap;
        logic              rise;
        logic              known;
        range_result_t     res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [TIME_W-1:0]  timebase_pos;
    logic [TIME_W-1:0]  start_stamp;
    logic               awaiting_fall;
    logic               trig_level;
    logic [TIME_W-1:0]  period_reg;
    logic [SPEED_W-1:0] speed_reg;

    range_result_t pending_ranges[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    stim_row_t directed_rows[21] = '{
        '{CMD_TICK, 16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_TICK, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_TICK, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h1234, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0100, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0200, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0100, 1'b0, 1'b1, '{1'b0, 1'b1, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'hFFFE, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'hFFF0, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0010, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0000, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0FFF, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0000, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h1000, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h5555, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_TICK, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'hAAAA, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0000, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_ECHO, 16'h0001, 1'b0, 1'b0, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}},
        '{CMD_TICK, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 12'd0, 10'd0}}
    };

    ultrasonic_echo_ranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic range_result_t predict_range(input logic cmd, input logic [TIME_W-1:0] cap,
                                                    input logic rise);
        range_result_t     r;
        logic [TIME_W-1:0] eff_period;
        logic [TIME_W-1:0] ticks;
        logic [63:0]       us;
        logic [31:0]       product;
        r = '0;
        if (cmd == CMD_TICK)
        begin
            eff_period = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
            timebase_pos = timebase_pos + 1'b1;
            if (timebase_pos == 16'd1)
                trig_level = 1'b1;
            if (timebase_pos == 16'd2)
                trig_level = 1'b0;
            if (timebase_pos >= eff_period)
                timebase_pos = '0;
        end
        else if (rise)
        begin
            if (!awaiting_fall)
            begin
                start_stamp = cap;
                awaiting_fall = 1'b1;
            end
        end
        else if (awaiting_fall)
        begin
            ticks = cap - start_stamp;
            us = 64'(ticks) * 64'(US_PER_SECOND) / TICKS_PER_SEC;
            r.pulse = (us > 64'(PULSE_MAX)) ? PULSE_MAX : us[TIME_W-1:0];
            product = 32'(speed_reg) * 32'(r.pulse);
            r.cm = CM_W'(product / DIST_DIVISOR);
            r.milli = MILLI_W'(((product % DIST_DIVISOR) * 1000) / DIST_DIVISOR);
            r.valid = 1'b1;
            awaiting_fall = 1'b0;
        end
        r.trig = trig_level;
        return r;
    endfunction

    task automatic report_error(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic push_item(input logic cmd, input logic [TIME_W-1:0] cap, input logic rise,
                             input logic known, input range_result_t typed);
        range_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(IN_DATA_W - TIME_W - 1){1'b0}}, rise, cap};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        r = predict_range(cmd, cap, rise);
        pending_ranges.push_back(known ? typed : r);
        @(negedge clk);
    endtask

    task automatic send_tick();
        push_item(CMD_TICK, 16'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    task automatic send_edge(input logic [TIME_W-1:0] cap, input logic rise);
        push_item(CMD_ECHO, cap, rise, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] period, input logic [SPEED_W-1:0] speed);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TRIGGER_PERIOD;
        cfg_data <= period;
        @(negedge clk);
        cfg_index <= CFG_SOUND_SPEED;
        cfg_data <= CFG_DATA_W'(speed);
        @(negedge clk);
        cfg_we <= 1'b0;
        period_reg = period;
        speed_reg = speed;
        @(negedge clk);
    endtask

    task automatic run_random(input int n);
        int                done;
        int                pick;
        int                wsel;
        int                gap;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] width;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                t0 = 16'($urandom);
                wsel = $urandom_range(9);
                if (wsel < 6)
                    width = 16'($urandom_range(0, 4095));
                else if (wsel < 8)
                    width = 16'($urandom);
                else
                    width = 16'($urandom_range(4090, 4100));
                gap = $urandom_range(0, 3);
                send_edge(t0, 1'b1);
                repeat (gap)
                    send_tick();
                send_edge(t0 + width, 1'b0);
                done += 2 + gap;
            end
            else if (pick < 85)
            begin
                send_tick();
                done++;
            end
            else
            begin
                send_edge(16'($urandom), 1'($urandom));
                done++;
            end
        end
    endtask

    // receiver: random stall, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        range_result_t want;
        range_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.trig = m_tdata[0];
            got.pulse = m_tdata[16:1];
            got.cm = m_tdata[28:17];
            got.milli = m_tdata[38:29];
            got.valid = m_tuser;
            if (pending_ranges.size() == 0)
                report_error("unexpected item, trigger_level", got.trig, 0);
            else
            begin
                want = pending_ranges.pop_front();
                if (got.trig !== want.trig)
                    report_error("trigger_level", got.trig, want.trig);
                if (got.valid !== want.valid)
                    report_error("measurement_valid", got.valid, want.valid);
                if (got.pulse !== want.pulse)
                    report_error("pulse_us", got.pulse, want.pulse);
                if (got.cm !== want.cm)
                    report_error("distance_cm", got.cm, want.cm);
                if (got.milli !== want.milli)
                    report_error("distance_milli", got.milli, want.milli);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ultrasonic_echo_ranger verification failed");
        $finish;
    end

    initial
    begin : stimulus
        timebase_pos = '0;
        start_stamp = '0;
        awaiting_fall = 1'b0;
        trig_level = 1'b0;
        period_reg = PERIOD_RESET;
        speed_reg = SPEED_RESET;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 28;
        recv_stall_pct = 56;
        foreach (directed_rows[i])
            push_item(directed_rows[i].cmd, directed_rows[i].cap, directed_rows[i].rise,
                      directed_rows[i].known, directed_rows[i].res);
        drain_results();

        // period below both the minimum and the current count
        set_config(16'd2, 6'd1);
        hold_req++;
        run_random(230);
        drain_results();

        send_idle_pct = 56;
        recv_stall_pct = 28;
        set_config(16'd65535, 6'd63);
        hold_req++;
        run_random(230);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(16'd3, 6'($urandom_range(1, 63)));
        run_random(220);
        drain_results();

        set_config(16'($urandom_range(0, 60)), 6'($urandom_range(1, 63)));
        run_random(220);
        drain_results();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("ultrasonic_echo_ranger verification clean");
        else
            $display("ultrasonic_echo_ranger verification failed");
        $finish;
    end

endmodule
